/* design/itvs_pkg.sv */
// Package for the incubator tray and vent sequencer: codes, widths and helpers.
package itvs_pkg;

  localparam int unsigned MinutesDay = 1440;
  localparam int unsigned PeriodW    = 11;
  localparam int unsigned OffsetW    = 10;
  localparam int unsigned MinW       = 12;

  typedef enum logic [2:0] {
    REG_ROT_PER_DAY  = 3'd0,
    REG_VENT_PER_DAY = 3'd1,
    REG_VENT_MIN     = 3'd2,
    REG_ROTATE_MS    = 3'd3,
    REG_DOOR_ALARM   = 3'd4,
    REG_VENT_SPEED   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRAY_NONE  = 2'd0,
    TRAY_STOP  = 2'd1,
    TRAY_RIGHT = 2'd2,
    TRAY_LEFT  = 2'd3
  } tray_cmd_t;

  typedef enum logic [1:0] {
    VENT_NONE  = 2'd0,
    VENT_PAUSE = 2'd1,
    VENT_OFF   = 2'd2,
    VENT_ON    = 2'd3
  } vent_cmd_t;

  typedef enum logic [1:0] {
    ALERT_NONE   = 2'd0,
    ALERT_OPENED = 2'd1,
    ALERT_CLOSED = 2'd2
  } alert_cmd_t;

  // Request to the shared restoring divider.
  typedef struct packed {
    logic            start;
    logic [MinW-1:0] dividend;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MinW-1:0] quotient;
    logic [PeriodW-1:0] remainder;
  } div_rsp_t;

endpackage

/* design/itvs_div.sv */
// Bit-serial restoring divider shared by schedule setup and schedule checks.
module itvs_div (
  input  logic               clk,
  input  logic               rst,
  input  itvs_pkg::div_req_t req,
  output itvs_pkg::div_rsp_t rsp
);
  import itvs_pkg::*;

  logic [MinW-1:0]    quo;
  logic [PeriodW:0]   rem;
  logic [PeriodW-1:0] dvs;
  logic [3:0]         cnt;
  logic               busy;
  logic               done_r;
  logic [PeriodW+1:0] trial;

  assign trial = {rem, quo[MinW-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= 4'(MinW - 1);
      end else if (busy) begin
        if (!trial[PeriodW+1]) begin
          rem <= trial[PeriodW:0];
          quo <= {quo[MinW-2:0], 1'b1};
        end else begin
          rem <= {rem[PeriodW-1:0], quo[MinW-1]};
          quo <= {quo[MinW-2:0], 1'b0};
        end
        if (cnt == 4'd0) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
        cnt <= cnt - 4'd1;
      end
    end
  end

  assign rsp = '{done: done_r, quotient: quo, remainder: rem[PeriodW-1:0]};

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start |=> busy || rsp.done) else $error("divider lost run");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held");
`endif
endmodule

/* design/incubator_tray_vent_sequencer.sv */
// Top level of the incubator tray and vent sequencer.
// Each item, init or refresh alike, passes through two 12-step runs of the shared divider
// (rotation, then ventilation) and a finishing step before its result is valid.
// The input stalls while the sequencer is busy, so a new item is taken only when it is idle.
// A result waits in the output register while the next item is computed.
// Reset (synchronous, active high) restores register defaults, clears state, skips schedules.
module incubator_tray_vent_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] now_ms,
  input  logic [4:0]  hour_now,
  input  logic [5:0]  minute_now,
  input  logic [5:0]  second_now,
  input  logic        door_open,
  input  logic        door_changed,
  input  logic        center_active,
  input  logic        center_changed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tray_action,
  output logic [1:0]  vent_action,
  output logic [1:0]  alert_event,
  output logic        alarm_start,
  output logic        heater_enable,
  output logic        humidifier_enable,
  output logic        rotating,
  output logic        venting,
  output logic        centered,
  output logic        door_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import itvs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_A, S_WAIT_A, S_DIV_B, S_WAIT_B, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]  rotations_per_day, vents_per_day, vent_minutes, vent_speed;
  logic [31:0] rotate_ms, door_alarm_ms;

  // Schedule and controller state.
  logic [PeriodW-1:0] rot_period, vent_period;
  logic [OffsetW-1:0] rot_offset, vent_offset;
  logic rot_skip, vent_skip;
  logic rotate_active, direction_toggle, at_center, need_center, vent_active;
  logic [31:0] rotate_start, vent_start, door_timer_start;
  logic restart_pending, heat_on, humid_on, door_flag;

  // Captured item.
  logic        it_mode, it_door, it_door_chg, it_center, it_center_chg;
  logic [31:0] it_now;
  logic [4:0]  it_hr;
  logic [5:0]  it_mn, it_sc;

  // Schedule results gathered from the divider.
  logic rot_due, vent_due;

  div_req_t dreq;
  div_rsp_t drsp;

  itvs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Minute of day from the captured hour and minute; the offsets are added below.
  logic [MinW-1:0] min_of_day;
  assign min_of_day = MinW'(it_hr) * MinW'(60) + MinW'(it_mn);

  // Phase A works on the rotation schedule, phase B on the ventilation one.
  // For init, the divider gives 1440 / count; for refresh, m mod period.
  logic [MinW-1:0] m_rot, m_vent;
  assign m_rot  = min_of_day + MinW'(rot_offset);
  assign m_vent = min_of_day + MinW'(vent_offset);

  always_comb begin
    dreq = '0;
    if (state == S_DIV_A) begin
      dreq.start = 1'b1;
      if (it_mode) begin
        dreq.dividend = MinW'(MinutesDay);
        dreq.divisor  = PeriodW'(rotations_per_day);
      end else begin
        dreq.dividend = m_rot;
        dreq.divisor  = rot_period;
      end
    end else if (state == S_DIV_B) begin
      dreq.start = 1'b1;
      if (it_mode) begin
        dreq.dividend = MinW'(MinutesDay);
        dreq.divisor  = PeriodW'(vents_per_day);
      end else begin
        dreq.dividend = m_vent;
        dreq.divisor  = vent_period;
      end
    end
  end

  // A quotient of zero cannot occur for counts up to 255, but is forced to one anyway.
  logic [PeriodW-1:0] q_period;
  assign q_period = (drsp.quotient == '0) ? PeriodW'(1) : drsp.quotient[PeriodW-1:0];

  logic sc_ok;
  assign sc_ok = it_sc < 6'd30;

  // The finishing state waits for the output register, so a waiting result
  // does not hold off the next item.
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Finishing step: the whole refresh or init update applied at once.
  logic [1:0]  tray_n, vent_n, alert_n;
  logic        alarm_n;
  logic        rot_act_n, dir_n, at_c_n, need_c_n, vent_act_n, rp_n, heat_n, humid_n, door_n;
  logic [31:0] rot_st_n, vent_st_n, door_st_n;
  logic [39:0] vent_dur;

  assign vent_dur = 40'(vent_minutes) * 40'd60000;

  always_comb begin
    tray_n = TRAY_NONE; vent_n = VENT_NONE; alert_n = ALERT_NONE; alarm_n = 1'b0;
    rot_act_n = rotate_active; dir_n = direction_toggle; at_c_n = at_center;
    need_c_n = need_center; vent_act_n = vent_active; rp_n = restart_pending;
    heat_n = heat_on; humid_n = humid_on; door_n = door_flag;
    rot_st_n = rotate_start; vent_st_n = vent_start; door_st_n = door_timer_start;
    if (it_mode) begin
      if (it_center) begin
        tray_n = TRAY_STOP; at_c_n = 1'b1; need_c_n = 1'b0;
      end
      if (rotations_per_day == 8'd0 && !at_c_n) need_c_n = 1'b1;
      door_st_n = it_now;
      rp_n = 1'b1;
    end else begin
      if (it_door_chg || restart_pending) begin
        rp_n = 1'b0;
        if (it_door) begin
          alert_n = ALERT_OPENED; door_st_n = it_now; humid_n = 1'b0; heat_n = 1'b0;
          vent_n = VENT_PAUSE; door_n = 1'b1;
          if (!at_c_n) need_c_n = 1'b1;
        end else begin
          alert_n = ALERT_CLOSED; humid_n = 1'b1; heat_n = 1'b1; door_n = 1'b0;
          need_c_n = 1'b0;
        end
      end
      if (it_center_chg && it_center && need_c_n) begin
        tray_n = TRAY_STOP; at_c_n = 1'b1; need_c_n = 1'b0;
      end
      if (rotate_active) begin
        if ((it_now - rotate_start) >= rotate_ms) begin
          rot_act_n = 1'b0; rot_st_n = '0; tray_n = TRAY_STOP;
        end
      end else if ((rot_due && !it_door) || need_c_n) begin
        rot_st_n = it_now; dir_n = !direction_toggle; at_c_n = 1'b0;
        tray_n = dir_n ? TRAY_RIGHT : TRAY_LEFT;
        rot_act_n = 1'b1;
      end
      if (it_door) begin
        if ((it_now - door_st_n) >= door_alarm_ms) begin
          door_st_n = it_now; alarm_n = 1'b1;
        end
        if (humid_n || heat_n) rp_n = 1'b1;
      end else if (vent_active) begin
        if ({8'd0, it_now - vent_start} >= vent_dur) begin
          vent_st_n = '0; vent_act_n = 1'b0; humid_n = 1'b1; vent_n = VENT_OFF;
        end
      end else if (vent_due) begin
        vent_n = VENT_ON; vent_st_n = it_now; vent_act_n = 1'b1; humid_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rotations_per_day <= 8'd0; vents_per_day <= 8'd0; vent_minutes <= 8'd0;
      rotate_ms <= 32'd10000; door_alarm_ms <= 32'd60000; vent_speed <= 8'd255;
      rot_period <= '0; rot_offset <= '0; rot_skip <= 1'b1;
      vent_period <= '0; vent_offset <= '0; vent_skip <= 1'b1;
      rotate_active <= 1'b0; rotate_start <= '0; direction_toggle <= 1'b0;
      at_center <= 1'b0; need_center <= 1'b0; vent_active <= 1'b0; vent_start <= '0;
      door_timer_start <= '0; restart_pending <= 1'b0; heat_on <= 1'b0;
      humid_on <= 1'b0; door_flag <= 1'b0;
      rot_due <= 1'b0; vent_due <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_PER_DAY:  rotations_per_day <= cfg_data[7:0];
          REG_VENT_PER_DAY: vents_per_day     <= cfg_data[7:0];
          REG_VENT_MIN:     vent_minutes      <= cfg_data[7:0];
          REG_ROTATE_MS:    rotate_ms         <= cfg_data;
          REG_DOOR_ALARM:   door_alarm_ms     <= cfg_data;
          REG_VENT_SPEED:   vent_speed        <= cfg_data[7:0];
          default: ;
        endcase
      end
      // In the finishing state a taken result is replaced by the new one below.
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            it_mode <= mode; it_now <= now_ms; it_hr <= hour_now; it_mn <= minute_now;
            it_sc <= second_now; it_door <= door_open; it_door_chg <= door_changed;
            it_center <= center_active; it_center_chg <= center_changed;
            state <= S_DIV_A;
          end
        end
        S_DIV_A: state <= S_WAIT_A;
        S_WAIT_A: begin
          if (drsp.done) begin
            if (it_mode) begin
              if (rotations_per_day == 8'd0) begin
                rot_period <= '0; rot_offset <= '0; rot_skip <= 1'b1;
              end else begin
                rot_period <= q_period;
                rot_offset <= OffsetW'(q_period >> 1);
                rot_skip   <= 1'b0;
              end
            end else begin
              rot_due <= !rot_skip && rot_period != '0 && drsp.remainder == '0 &&
                         m_rot <= MinW'(MinutesDay) && sc_ok;
            end
            state <= S_DIV_B;
          end
        end
        S_DIV_B: state <= S_WAIT_B;
        S_WAIT_B: begin
          if (drsp.done) begin
            if (it_mode) begin
              if (vents_per_day == 8'd0) begin
                vent_period <= '0; vent_offset <= '0; vent_skip <= 1'b1;
              end else begin
                vent_period <= q_period;
                vent_offset <= OffsetW'(q_period >> 1);
                vent_skip   <= 1'b0;
              end
            end else begin
              vent_due <= !vent_skip && vent_period != '0 && drsp.remainder == '0 &&
                          m_vent <= MinW'(MinutesDay) && sc_ok;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            tray_action <= tray_n; vent_action <= vent_n; alert_event <= alert_n;
            alarm_start <= alarm_n;
            rotate_active <= rot_act_n; direction_toggle <= dir_n; at_center <= at_c_n;
            need_center <= need_c_n; vent_active <= vent_act_n; restart_pending <= rp_n;
            heat_on <= heat_n; humid_on <= humid_n; door_flag <= door_n;
            rotate_start <= rot_st_n; vent_start <= vent_st_n;
            door_timer_start <= door_st_n;
            heater_enable <= heat_n; humidifier_enable <= humid_n;
            rotating <= rot_act_n; venting <= vent_act_n;
            centered <= at_c_n; door_status <= door_n;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_rot_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && $rose(out_valid) && rotating && tray_action == TRAY_RIGHT |-> !centered)
    else $error("rotation started while centered");
`endif
endmodule

/* bench/incubator_tray_vent_sequencer_chk.sv */
`timescale 1ns / 1ps
// Checker for the incubator tray and vent sequencer: predicts and compares results.
module incubator_tray_vent_sequencer_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [31:0] now_ms,
  input  logic [4:0]  hour_now,
  input  logic [5:0]  minute_now,
  input  logic [5:0]  second_now,
  input  logic        door_open,
  input  logic        door_changed,
  input  logic        center_active,
  input  logic        center_changed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  tray_action,
  input  logic [1:0]  vent_action,
  input  logic [1:0]  alert_event,
  input  logic        alarm_start,
  input  logic        heater_enable,
  input  logic        humidifier_enable,
  input  logic        rotating,
  input  logic        venting,
  input  logic        centered,
  input  logic        door_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  import itvs_pkg::*;

  typedef struct packed {
    tray_cmd_t  tray;
    vent_cmd_t  vent;
    alert_cmd_t alert;
    logic       alarm;
    logic       heat;
    logic       humid;
    logic       rot;
    logic       vnt;
    logic       ctr;
    logic       door;
  } step_result_t;

  step_result_t result_q[$];

  logic [7:0]  rot_count, vent_count, vent_len_min, fan_speed;
  logic [31:0] turn_ms, alarm_ms;
  logic [10:0] rot_per, vent_per;
  logic [9:0]  rot_off, vent_off;
  logic        rot_off_sched, vent_off_sched;
  logic        turning, dir, at_ctr, want_ctr, airing, restart, heat, humid, dflag;
  logic [31:0] turn_t0, air_t0, door_t0;

  function automatic logic expired(logic [31:0] t, logic [31:0] t0, logic [31:0] dur);
    logic [31:0] d;
    d = t - t0;
    return d >= dur;
  endfunction

  function automatic logic slot_due(logic [10:0] per, logic [9:0] off, logic skip,
                                    logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
    int unsigned m;
    if (skip || per == 0) return 1'b0;
    m = hr * 60 + mn + off;
    return (m % per == 0) && (m <= MinutesDay) && (sc < 30);
  endfunction

  task automatic schedule_from(input logic [7:0] cnt, output logic [10:0] per,
                               output logic [9:0] off, output logic skip);
    int unsigned p;
    if (cnt == 0) begin
      per = 0;
      off = 0;
      skip = 1'b1;
    end else begin
      p = MinutesDay / cnt;
      if (p == 0) p = 1;
      per = p[10:0];
      off = 10'(p / 2);
      skip = 1'b0;
    end
  endtask

  task automatic predict_step();
    step_result_t r;
    r = '0;
    if (mode) begin
      if (center_active) begin
        r.tray = TRAY_STOP;
        at_ctr = 1;
        want_ctr = 0;
      end
      schedule_from(rot_count, rot_per, rot_off, rot_off_sched);
      if (rot_off_sched && !at_ctr) want_ctr = 1;
      schedule_from(vent_count, vent_per, vent_off, vent_off_sched);
      door_t0 = now_ms;
      restart = 1;
    end else begin
      if (door_changed || restart) begin
        restart = 0;
        if (door_open) begin
          r.alert = ALERT_OPENED;
          door_t0 = now_ms;
          humid = 0;
          heat = 0;
          r.vent = VENT_PAUSE;
          dflag = 1;
          if (!at_ctr) want_ctr = 1;
        end else begin
          r.alert = ALERT_CLOSED;
          humid = 1;
          heat = 1;
          dflag = 0;
          want_ctr = 0;
        end
      end
      if (center_changed && center_active && want_ctr) begin
        r.tray = TRAY_STOP;
        at_ctr = 1;
        want_ctr = 0;
      end
      if (turning) begin
        if (expired(now_ms, turn_t0, turn_ms)) begin
          turning = 0;
          turn_t0 = 0;
          r.tray = TRAY_STOP;
        end
      end else if ((slot_due(rot_per, rot_off, rot_off_sched, hour_now, minute_now,
                             second_now) && !door_open) || want_ctr) begin
        turn_t0 = now_ms;
        dir = !dir;
        at_ctr = 0;
        r.tray = dir ? TRAY_RIGHT : TRAY_LEFT;
        turning = 1;
      end
      if (door_open) begin
        if (expired(now_ms, door_t0, alarm_ms)) begin
          door_t0 = now_ms;
          r.alarm = 1;
        end
        if (humid || heat) restart = 1;
      end else if (airing) begin
        if (expired(now_ms, air_t0, vent_len_min * 32'd60000)) begin
          air_t0 = 0;
          airing = 0;
          humid = 1;
          r.vent = VENT_OFF;
        end
      end else if (slot_due(vent_per, vent_off, vent_off_sched, hour_now, minute_now,
                            second_now)) begin
        r.vent = VENT_ON;
        air_t0 = now_ms;
        airing = 1;
        humid = 0;
      end
    end
    r.heat = heat;
    r.humid = humid;
    r.rot = turning;
    r.vnt = airing;
    r.ctr = at_ctr;
    r.door = dflag;
    result_q.push_back(r);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    step_result_t e;
    if (rst) begin
      rot_count = 0; vent_count = 0; vent_len_min = 0;
      turn_ms = 10000; alarm_ms = 60000; fan_speed = 255;
      rot_per = 0; rot_off = 0; rot_off_sched = 1;
      vent_per = 0; vent_off = 0; vent_off_sched = 1;
      turning = 0; dir = 0; at_ctr = 0; want_ctr = 0; airing = 0;
      restart = 0; heat = 0; humid = 0; dflag = 0;
      turn_t0 = 0; air_t0 = 0; door_t0 = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_PER_DAY:  rot_count = cfg_data[7:0];
          REG_VENT_PER_DAY: vent_count = cfg_data[7:0];
          REG_VENT_MIN:     vent_len_min = cfg_data[7:0];
          REG_ROTATE_MS:    turn_ms = cfg_data;
          REG_DOOR_ALARM:   alarm_ms = cfg_data;
          REG_VENT_SPEED:   fan_speed = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = result_q.pop_front();
          compare_field("tray_action", e.tray, tray_action);
          compare_field("vent_action", e.vent, vent_action);
          compare_field("alert_event", e.alert, alert_event);
          compare_field("alarm_start", e.alarm, alarm_start);
          compare_field("heater_enable", e.heat, heater_enable);
          compare_field("humidifier_enable", e.humid, humidifier_enable);
          compare_field("rotating", e.rot, rotating);
          compare_field("venting", e.vnt, venting);
          compare_field("centered", e.ctr, centered);
          compare_field("door_status", e.door, door_status);
        end
      end
      if (in_valid && !in_stall) predict_step();
    end
    pending_count = result_q.size();
  end

  initial fail_count = 0;

endmodule

/* bench/incubator_tray_vent_sequencer_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the incubator tray and vent sequencer.
module incubator_tray_vent_sequencer_tb;
  import itvs_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        mode = 0;
  logic [31:0] now_ms = 0;
  logic [4:0]  hour_now = 0;
  logic [5:0]  minute_now = 0;
  logic [5:0]  second_now = 0;
  logic        door_open = 0;
  logic        door_changed = 0;
  logic        center_active = 0;
  logic        center_changed = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  tray_action, vent_action, alert_event;
  logic        alarm_start, heater_enable, humidifier_enable;
  logic        rotating, venting, centered, door_status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int          fail_count, pending_count;
  int          cycle_count = 0;
  int          stall_run = 0;

  // A run needs about 2000 items; the limit leaves room for output stalls.
  localparam int CycleLimit = 3000000;

  // Simulated clock of the incubator: the time of day and the millisecond
  // counter advance together, so timed rotation and venting actually expire.
  logic [31:0] sim_ms;
  int          sim_min;
  logic        door_level, center_level;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  incubator_tray_vent_sequencer dut (.*);

  incubator_tray_vent_sequencer_chk chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("incubator_tray_vent_sequencer regression: fail");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // The receiving side stalls for runs of random length, independent of the stimulus.
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run <= stall_run - 1;
      end else begin
        out_stall <= 1'b0;
        stall_run <= gap_len();
      end
    end
  end

  // Valid stays high when the next item follows with no gap.
  task automatic send_item(logic m, logic [31:0] t, logic [4:0] h, logic [5:0] mn,
                           logic [5:0] s, logic dopen, logic dchg, logic cact,
                           logic cchg);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    now_ms <= t;
    hour_now <= h;
    minute_now <= mn;
    second_now <= s;
    door_open <= dopen;
    door_changed <= dchg;
    center_active <= cact;
    center_changed <= cchg;
    do @(posedge clk); while (in_stall);
  endtask

  // Registers change only once every expected result has come back.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // A realistic refresh: time of day follows sim_ms, door and center
  // switches toggle now and then with matching change flags.
  task automatic realistic_step();
    logic dc, cc;
    sim_ms += $urandom_range(0, 99) < 70 ? $urandom_range(1, 30000) : $urandom_range(0, 900000);
    sim_min = (sim_ms / 60000) % 1440;
    dc = $urandom_range(0, 99) < 8;
    cc = $urandom_range(0, 99) < 15;
    if (dc) door_level = !door_level;
    if (cc) center_level = !center_level;
    send_item($urandom_range(0, 99) < 3, sim_ms, 5'(sim_min / 60), 6'(sim_min % 60),
              6'((sim_ms / 1000) % 60), door_level, dc, center_level, cc);
  endtask

  task automatic random_setup(int k);
    logic [7:0] rc, vc;
    rc = (k % 4 == 0) ? 8'd0 : (k % 4 == 1) ? 8'd255 : 8'($urandom_range(1, 48));
    vc = (k % 5 == 0) ? 8'd0 : (k % 5 == 1) ? 8'd255 : 8'($urandom_range(1, 48));
    write_reg(REG_ROT_PER_DAY, rc);
    write_reg(REG_VENT_PER_DAY, vc);
    write_reg(REG_VENT_MIN, (k % 3 == 0) ? 8'd0 : 8'($urandom_range(1, 30)));
    write_reg(REG_ROTATE_MS, (k % 6 == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 120000));
    write_reg(REG_DOOR_ALARM, (k % 7 == 0) ? 32'd0 : $urandom_range(1000, 200000));
    write_reg(REG_VENT_SPEED, $urandom);
    send_item(1, sim_ms, 5'(sim_min / 60), 6'(sim_min % 60), 0, door_level, 0,
              center_level, 0);
  endtask

  initial begin
    sim_ms = 0;
    sim_min = 0;
    door_level = 0;
    center_level = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: refresh before any init, init with and without center,
    // door opening and closing, alarm timeout, schedule hits at minute zero
    // and at the end of day, field extremes, and the unused register index.
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, 32'hFFFF_FFFF, 31, 63, 63, 1, 1, 0, 0);
    write_reg(REG_ROT_PER_DAY, 8'd24);
    write_reg(REG_VENT_PER_DAY, 8'd1);
    write_reg(REG_VENT_MIN, 8'd255);
    write_reg(REG_ROTATE_MS, 32'd0);
    write_reg(REG_DOOR_ALARM, 32'd5);
    write_reg(REG_VENT_SPEED, 8'd0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= 3'd7;
    cfg_data <= 32'hFFFF_FFFF;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    send_item(1, 100, 0, 0, 0, 0, 0, 1, 1);
    send_item(0, 200, 0, 30, 10, 0, 0, 1, 0);
    send_item(0, 300, 0, 30, 10, 0, 0, 0, 1);
    send_item(0, 400, 12, 0, 29, 0, 0, 0, 0);
    send_item(0, 500, 12, 0, 30, 1, 1, 0, 0);
    send_item(0, 505, 12, 0, 40, 1, 0, 1, 1);
    send_item(0, 32'hFFFF_FFFF, 23, 59, 59, 1, 0, 0, 1);
    send_item(0, 600, 23, 30, 0, 0, 1, 0, 0);
    send_item(0, 700, 24, 0, 0, 0, 0, 1, 1);
    send_item(0, 800, 31, 63, 63, 0, 1, 1, 1);
    send_item(0, 900, 0, 0, 0, 0, 0, 0, 0);

    // Random part: several register settings, each with an init followed by
    // mostly coherent refreshes and some fully random items.
    for (int k = 0; k < 12; k++) begin
      random_setup(k);
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(0, 99) < 85)
          realistic_step();
        else
          send_item(1'($urandom_range(0, 1)), $urandom, 5'($urandom), 6'($urandom),
                    6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom));
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("incubator_tray_vent_sequencer regression: pass");
    else
      $display("incubator_tray_vent_sequencer regression: fail");
    $finish;
  end

endmodule
